// ===== hdl/region_descriptor_merge_distance_top_assert.svh =====
// Assertion macros for the region descriptor merge and distance block.
`ifndef REGION_DESCRIPTOR_MERGE_DISTANCE_TOP_ASSERT_SVH
`define REGION_DESCRIPTOR_MERGE_DISTANCE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RDMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`define RDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RDMD_ASSERT(lbl, prop, msg)

`define RDMD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/rdmd_pkg.sv =====
// Shared types and constants for the region descriptor merge and distance block.
`timescale 1ns / 1ps

package rdmd_pkg;

  localparam int FEAT_W    = 16;  // Q8.8 feature
  localparam int IDX_W     = 6;
  localparam int RCNT_W    = 24;  // region_count field
  localparam int DIST_W    = 22;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 24;  // total_count field
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 48;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_MERGE  = 2'd1,
    KIND_DIST   = 2'd2,
    KIND_IGNORE = 2'd3
  } rdmd_kind_t;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

  // merge unit status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rdmd_mu_stat_t;

endpackage

// ===== hdl/rdmd_merge_unit.sv =====
// Bit-serial weighted mean: shift-add multiply then restoring divide.
`timescale 1ns / 1ps

module rdmd_merge_unit import rdmd_pkg::*; #(
  parameter int CNT_W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [FEAT_W-1:0]   old_val,
  input  logic [FEAT_W-1:0]   new_val,
  input  logic [CNT_W-1:0]    old_cnt,
  input  logic [CNT_W-1:0]    new_cnt,
  input  logic [CNT_W:0]      total,    // nonzero
  output logic [FEAT_W-1:0]   quot,
  output rdmd_mu_stat_t       stat
);

  localparam int WS_W   = CNT_W + FEAT_W + 1;
  localparam int STEP_W = $clog2(FEAT_W);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_t;

  ustate_t             state;
  logic [STEP_W-1:0]   step;
  logic [FEAT_W-1:0]   a_sh;
  logic [FEAT_W-1:0]   b_sh;
  logic [CNT_W-1:0]    wa;
  logic [CNT_W-1:0]    wb;
  logic [CNT_W:0]      tot;
  logic [WS_W-1:0]     ws;
  logic [CNT_W:0]      rem;
  logic [FEAT_W-1:0]   lo;       // dividend low bits, quotient shifts in behind
  logic                done;

  logic [WS_W-1:0]     ws_next;
  logic [CNT_W+1:0]    cat;
  logic [CNT_W+1:0]    trial;
  logic                ge;
  logic [CNT_W:0]      rem_next;

  // MSB-first shift-add of both products at once
  assign ws_next = (ws << 1)
                 + (a_sh[FEAT_W-1] ? WS_W'(wa) : '0)
                 + (b_sh[FEAT_W-1] ? WS_W'(wb) : '0);

  assign cat      = {rem, lo[FEAT_W-1]};
  assign trial    = cat - {1'b0, tot};
  assign ge       = !trial[CNT_W+1];
  assign rem_next = ge ? trial[CNT_W:0] : cat[CNT_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      // pulse after the last divide step
      done <= (state == U_DIV) && (step == '0);
      unique case (state)
        U_IDLE: begin
          if (start) begin
            a_sh  <= old_val;
            b_sh  <= new_val;
            wa    <= old_cnt;
            wb    <= new_cnt;
            tot   <= total;
            ws    <= '0;
            step  <= STEP_W'(FEAT_W - 1);
            state <= U_MUL;
          end
        end
        U_MUL: begin
          ws   <= ws_next;
          a_sh <= a_sh << 1;
          b_sh <= b_sh << 1;
          if (step == '0) begin
            // quotient fits FEAT_W bits, so the high part is already below total
            rem   <= ws_next[WS_W-1:FEAT_W];
            lo    <= ws_next[FEAT_W-1:0];
            step  <= STEP_W'(FEAT_W - 1);
            state <= U_DIV;
          end else begin
            step <= step - 1'b1;
          end
        end
        U_DIV: begin
          rem  <= rem_next;
          lo   <= {lo[FEAT_W-2:0], ge};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign quot      = lo;
  assign stat.busy = (state != U_IDLE);
  assign stat.done = done;

endmodule

// ===== hdl/region_descriptor_merge_distance_top.sv =====
// Top level of the region descriptor merge and distance block.
`timescale 1ns / 1ps

// Holds one region descriptor (VECTOR_LEN unsigned Q8.8 features plus a pixel
// count) and processes one element per input beat. tuser selects load, merge
// or distance; code 3 is dropped without a result. Load writes the element;
// merge replaces it with floor((stored*stored_count + in*region_count)/total);
// distance accumulates |stored - in| into a 22-bit saturating sum. A beat with
// tlast commits the count (load: region_count, merge: stored+region, distance:
// unchanged, saturated to COUNT_BITS bits with status 2; a zero merge total
// gives status 1, first flag wins) and emits one result beat. Elements with an
// index at or past VECTOR_LEN touch neither store nor sum. Sequencing: a load or
// distance element, or a merge element out of range or with a zero total,
// passes through the execute and finish states before the next accept; a merge
// element in range with a nonzero total also waits in the wait state for the
// bit-serial merge unit (shift-add multiply, then restoring divide, one bit per
// cycle); a dropped beat leaves the block idle. A last beat waits in its final
// state while the previous result is still unread.
// Feature store entries are undefined until loaded.

module region_descriptor_merge_distance_top import rdmd_pkg::*; #(
  parameter int VECTOR_LEN = 64,
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [5:0] elem_index, [21:6] element_value, [45:22] region_count, [47:46] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]          s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [21:0] distance, [45:22] total_count, [47:46] status
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  `include "region_descriptor_merge_distance_top_assert.svh"

  localparam int AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int CW = (COUNT_BITS > RCNT_W) ? COUNT_BITS : RCNT_W;
  localparam int TW = CW + 1;
  localparam logic [TW-1:0] CMAX = TW'((64'd1 << COUNT_BITS) - 64'd1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_FIN} state_t;

  state_t               state;

  // latched beat
  rdmd_kind_t           op_kind;
  logic [AW-1:0]        op_addr;
  logic                 op_range;
  logic [FEAT_W-1:0]    op_val;
  logic [RCNT_W-1:0]    op_rc;
  logic                 op_last;

  logic [COUNT_BITS-1:0] stored_count;
  logic [DIST_W-1:0]    dsum;
  logic [STAT_W-1:0]    pending_status;
  logic                 wr_pend;
  logic [FEAT_W-1:0]    wr_val;

  logic [FEAT_W-1:0]    feat_mem [VECTOR_LEN];
  logic [FEAT_W-1:0]    rd_data;

  // input unpack
  rdmd_kind_t           in_kind;
  logic [IDX_W-1:0]     in_idx;
  logic [FEAT_W-1:0]    in_val;
  logic [RCNT_W-1:0]    in_rc;
  logic [AW+IDX_W-1:0]  idx_wide;
  logic [AW-1:0]        in_addr;
  logic                 in_range;
  logic                 accept;

  logic [TW-1:0]        op_total;
  logic                 mu_start;
  logic [FEAT_W-1:0]    mu_q;
  rdmd_mu_stat_t        mu_stat;

  logic [FEAT_W-1:0]    diff;
  logic [DIST_W:0]      dsum_add;
  logic [DIST_W-1:0]    dsum_sat;

  logic [TW-1:0]        commit_raw;
  logic                 commit_sat;
  logic [COUNT_BITS-1:0] commit_cnt;
  logic [COUNT_BITS-1:0] cnt_fin;
  logic [CW-1:0]        cnt_ext;
  logic [STAT_W-1:0]    status_fin;
  logic [DIST_W-1:0]    dist_fin;
  logic                 mem_we;
  logic                 out_load;

  assign in_kind  = rdmd_kind_t'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_val   = s_axis_tdata[IDX_W +: FEAT_W];
  assign in_rc    = s_axis_tdata[IDX_W+FEAT_W +: RCNT_W];
  assign idx_wide = (AW+IDX_W)'(in_idx);
  assign in_addr  = idx_wide[AW-1:0];
  assign in_range = int'(in_idx) < VECTOR_LEN;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // exact sum, one bit wider than either count
  assign op_total = TW'(stored_count) + TW'(op_rc);
  assign mu_start = (state == S_EXEC) && (op_kind == KIND_MERGE) && op_range
                  && (op_total != '0);

  rdmd_merge_unit #(
    .CNT_W (CW)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .start   (mu_start),
    .old_val (rd_data),
    .new_val (op_val),
    .old_cnt (CW'(stored_count)),
    .new_cnt (CW'(op_rc)),
    .total   (op_total),
    .quot    (mu_q),
    .stat    (mu_stat)
  );

  // distance accumulate, saturating
  assign diff     = (rd_data > op_val) ? (rd_data - op_val) : (op_val - rd_data);
  assign dsum_add = {1'b0, dsum} + (DIST_W+1)'(diff);
  assign dsum_sat = dsum_add[DIST_W] ? DIST_MAX : dsum_add[DIST_W-1:0];

  // commit on last
  assign commit_raw = (op_kind == KIND_LOAD) ? TW'(op_rc) : op_total;
  assign commit_sat = (op_kind != KIND_DIST) && (commit_raw > CMAX);
  assign commit_cnt = commit_sat ? CMAX[COUNT_BITS-1:0] : commit_raw[COUNT_BITS-1:0];
  assign cnt_fin    = (op_kind == KIND_DIST) ? stored_count : commit_cnt;
  assign cnt_ext    = CW'(cnt_fin);
  assign dist_fin   = (op_kind == KIND_DIST) ? dsum : '0;

  always_comb begin
    if (pending_status != ST_OK) begin
      status_fin = pending_status;
    end else if ((op_kind == KIND_MERGE) && (op_total == '0)) begin
      status_fin = ST_ZERO;
    end else if (commit_sat) begin
      status_fin = ST_SAT;
    end else begin
      status_fin = ST_OK;
    end
  end

  assign mem_we = (state == S_FIN) && wr_pend;

  // result register free or draining this cycle
  assign out_load = (state == S_FIN) && op_last && (!m_axis_tvalid || m_axis_tready);

  // feature store, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= feat_mem[in_addr];
    end
    if (mem_we) begin
      feat_mem[op_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      stored_count   <= '0;
      dsum           <= '0;
      pending_status <= ST_OK;
      wr_pend        <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_kind != KIND_IGNORE)) begin
            op_kind  <= in_kind;
            op_addr  <= in_addr;
            op_range <= in_range;
            op_val   <= in_val;
            op_rc    <= in_rc;
            op_last  <= s_axis_tlast;
            wr_pend  <= 1'b0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_kind)
            KIND_LOAD: begin
              wr_pend <= op_range;
              wr_val  <= op_val;
              state   <= S_FIN;
            end
            KIND_MERGE: begin
              if (!op_range) begin
                state <= S_FIN;
              end else if (op_total == '0) begin
                wr_pend <= 1'b1;
                wr_val  <= '0;
                if (pending_status == ST_OK) begin
                  pending_status <= ST_ZERO;
                end
                state <= S_FIN;
              end else begin
                state <= S_WAIT;
              end
            end
            KIND_DIST: begin
              if (op_range) begin
                dsum <= dsum_sat;
              end
              state <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_WAIT: begin
          if (mu_stat.done) begin
            wr_pend <= 1'b1;
            wr_val  <= mu_q;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!op_last) begin
            state <= S_IDLE;
          end else if (out_load) begin
            m_axis_tdata   <= {status_fin, cnt_ext[OUT_CNT_W-1:0], dist_fin};
            stored_count   <= cnt_fin;
            dsum           <= '0;
            pending_status <= ST_OK;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RDMD_ASSERT(a_done_in_wait, mu_stat.done |-> state == S_WAIT, "merge result outside wait")
  `RDMD_ASSERT_NEXT(a_div_writes, mu_stat.done, state == S_FIN && wr_pend, "merge result not stored")
  `RDMD_ASSERT(a_out_from_fin, $rose(m_axis_tvalid) |-> $past(state) == S_FIN && $past(op_last), "result beat without last")
  `RDMD_ASSERT(a_busy_no_accept, mu_stat.busy |-> !s_axis_tready, "beat taken during merge")
  `RDMD_ASSERT(a_status_code, pending_status == ST_OK || pending_status == ST_ZERO || pending_status == ST_SAT, "bad pending status")

endmodule

// ===== tb/sv/tb_region_descriptor_merge_distance_top.sv =====
// Self-checking testbench for the region descriptor merge and distance block.
`timescale 1ns / 1ps

module tb_region_descriptor_merge_distance_top;
  import rdmd_pkg::*;

  localparam int                 CYCLE_LIMIT = 1_000_000;
  localparam int                 RAND_ELEMS  = 1700;
  localparam logic [RCNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [FEAT_W-1:0]  FEAT_MAX    = '1;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = KIND_LOAD;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // result beat layout, lowest field last in the packed struct
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OUT_CNT_W-1:0] total_count;
    logic [DIST_W-1:0]    distance;
  } descriptor_result_t;

  // Mirrors the descriptor state and queues the result each last beat yields.
  class descriptor_sb;
    logic [FEAT_W-1:0]  feature_mem [64];
    logic [RCNT_W-1:0]  count_q;
    logic [DIST_W-1:0]  dist_acc;
    logic [STAT_W-1:0]  flag_q;
    descriptor_result_t pending_results [$];
    int                 errors;

    function new();
      foreach (feature_mem[i]) feature_mem[i] = '0;
      count_q  = '0;
      dist_acc = '0;
      flag_q   = ST_OK;
      errors   = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // first flag in a vector wins
    function void raise_flag(logic [STAT_W-1:0] code);
      if (flag_q == ST_OK) flag_q = code;
    endfunction

    function logic [RCNT_W-1:0] clamp_count(longint unsigned c);
      if (c > longint'(COUNT_MAX)) begin
        raise_flag(ST_SAT);
        return COUNT_MAX;
      end
      return c[RCNT_W-1:0];
    endfunction

    // index is 6 bits and the store is 64 deep, so every element is in range
    function void note_element(rdmd_kind_t kind, logic [IDX_W-1:0] idx,
                               logic [FEAT_W-1:0] val, logic [RCNT_W-1:0] rc,
                               logic last);
      longint unsigned    total;
      longint unsigned    wsum;
      longint unsigned    diff;
      longint unsigned    acc;
      logic [RCNT_W-1:0]  committed;
      descriptor_result_t res;
      if (kind == KIND_IGNORE) return;
      committed = count_q;
      total     = 64'(count_q) + 64'(rc);
      case (kind)
        KIND_LOAD: begin
          feature_mem[idx] = val;
          if (last) committed = clamp_count(64'(rc));
        end
        KIND_MERGE: begin
          if (total == 0) begin
            feature_mem[idx] = '0;
            raise_flag(ST_ZERO);
          end else begin
            wsum = 64'(feature_mem[idx]) * 64'(count_q) + 64'(val) * 64'(rc);
            feature_mem[idx] = FEAT_W'(wsum / total);
          end
          if (last) begin
            if (total == 0) raise_flag(ST_ZERO);
            committed = clamp_count(total);
          end
        end
        default: begin
          diff = (feature_mem[idx] > val) ? 64'(feature_mem[idx] - val)
                                          : 64'(val - feature_mem[idx]);
          acc = 64'(dist_acc) + diff;
          dist_acc = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
        end
      endcase
      if (!last) return;
      count_q          = committed;
      res.distance     = (kind == KIND_DIST) ? dist_acc : '0;
      res.total_count  = count_q;
      res.status       = flag_q;
      pending_results  = {pending_results, res};
      dist_acc = '0;
      flag_q   = ST_OK;
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      descriptor_result_t got;
      descriptor_result_t want;
      got = descriptor_result_t'(data);
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%012h", data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.distance != want.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", want.distance, got.distance);
        errors++;
      end
      if (got.total_count != want.total_count) begin
        $error("total_count mismatch: expected %0d, actual %0d",
               want.total_count, got.total_count);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  descriptor_sb sb;

  region_descriptor_merge_distance_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // accepted beats on both sides, sampled at the edge that accepts them
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_element(rdmd_kind_t'(s_axis_tuser), s_axis_tdata[5:0],
                        s_axis_tdata[21:6], s_axis_tdata[45:22], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  // receiver stalls: a random mode is redrawn each time the phase counter runs out
  int rx_mode  = 0;
  int rx_phase = 0;
  int rx_hold  = 0;

  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_phase <= $urandom_range(100, 400);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: begin
        if (rx_hold == 0) begin
          m_axis_tready <= ~m_axis_tready;
          rx_hold       <= $urandom_range(1, 40);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_region_descriptor_merge_distance_top: FAIL");
      $finish;
    end
  end

  bit loaded [64];
  int burst_left;
  int elems_sent;

  // one input beat; opens a new burst with a random gap when the last one ran out
  task automatic send_element(input rdmd_kind_t kind, input logic [IDX_W-1:0] idx,
                              input logic [FEAT_W-1:0] val,
                              input logic [RCNT_W-1:0] rc, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, rc, val, idx};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind != KIND_IGNORE) elems_sent++;
    if (kind == KIND_LOAD || kind == KIND_MERGE) loaded[idx] = 1'b1;
  endtask

  // hold the sender until every queued result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // merge and distance only read entries that were loaded before
  function automatic logic [IDX_W-1:0] pick_loaded();
    logic [IDX_W-1:0] i;
    i = IDX_W'($urandom_range(0, 63));
    while (!loaded[i]) i = IDX_W'($urandom_range(0, 63));
    return i;
  endfunction

  function automatic logic [FEAT_W-1:0] rand_feature();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FEAT_MAX;
      default: return FEAT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RCNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r == 2) return COUNT_MAX;
    if (r < 8) return RCNT_W'($urandom & 32'h00FF_FFFF);
    return RCNT_W'($urandom_range(1, 255));
  endfunction

  initial begin
    rdmd_kind_t       vkind;
    rdmd_kind_t       kind;
    logic [IDX_W-1:0] idx;
    int               len;
    int               pick;
    sb         = new();
    burst_left = 0;
    elems_sent = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero total, saturation, ignored kind, mixed vector
    send_element(KIND_IGNORE, 6'd17, FEAT_MAX, COUNT_MAX, 1'b1);
    send_element(KIND_LOAD,   6'd0,  FEAT_MAX, '0, 1'b0);
    send_element(KIND_LOAD,   6'd63, '0,       '0, 1'b0);
    send_element(KIND_LOAD,   6'd42, 16'h8000, '0, 1'b1);
    send_element(KIND_MERGE,  6'd0,  16'h1234, '0, 1'b0);  // zero total
    send_element(KIND_MERGE,  6'd63, FEAT_MAX, '0, 1'b1);
    send_element(KIND_LOAD,   6'd0,  FEAT_MAX, COUNT_MAX, 1'b1);
    send_element(KIND_MERGE,  6'd0,  '0,       COUNT_MAX, 1'b1);  // count saturates
    send_element(KIND_LOAD,   6'd63, FEAT_MAX, '0, 1'b0);
    send_element(KIND_LOAD,   6'd1,  '0,       24'd1, 1'b1);
    send_element(KIND_DIST,   6'd63, '0,       '0, 1'b0);
    send_element(KIND_DIST,   6'd0,  FEAT_MAX, '0, 1'b0);
    send_element(KIND_DIST,   6'd42, 16'h8000, '0, 1'b1);
    send_element(KIND_MERGE,  6'd1,  FEAT_MAX, 24'd3, 1'b1);
    send_element(KIND_IGNORE, 6'd5,  '0,       '0, 1'b0);
    send_element(KIND_DIST,   6'd1,  FEAT_MAX, COUNT_MAX, 1'b1);
    send_element(KIND_LOAD,   6'd21, 16'hAAAA, 24'h555555, 1'b0);
    send_element(KIND_LOAD,   6'd42, 16'h5555, 24'hAAAAAA, 1'b1);
    send_element(KIND_MERGE,  6'd21, 16'h5555, '0, 1'b0);
    send_element(KIND_DIST,   6'd21, '0,       '0, 1'b1);  // mixed vector, distance last
    wait_drained();

    elems_sent = 0;
    while (elems_sent < RAND_ELEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // repeated full-scale differences on one entry drive the sum to saturation
        idx = IDX_W'($urandom_range(0, 63));
        send_element(KIND_LOAD, idx, '0, rand_count(), 1'b0);
        len = $urandom_range(65, 72);
        for (int e = 0; e < len; e++)
          send_element(KIND_DIST, idx, FEAT_MAX, rand_count(), e == len - 1);
      end else begin
        case ($urandom_range(0, 2))
          0:       vkind = KIND_LOAD;
          1:       vkind = KIND_MERGE;
          default: vkind = KIND_DIST;
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(1, 6);
        for (int e = 0; e < len; e++) begin
          kind = vkind;
          if ($urandom_range(0, 9) == 0) kind = rdmd_kind_t'($urandom_range(0, 2));
          idx = (kind == KIND_LOAD) ? 6'($urandom_range(0, 63)) : pick_loaded();
          if ($urandom_range(0, 19) == 0)
            send_element(KIND_IGNORE, 6'($urandom_range(0, 63)), rand_feature(),
                         rand_count(), 1'($urandom_range(0, 1)));
          send_element(kind, idx, rand_feature(), rand_count(), e == len - 1);
        end
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_region_descriptor_merge_distance_top: PASS");
    end else begin
      $display("tb_region_descriptor_merge_distance_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rdmd_pkg.sv
hdl/rdmd_merge_unit.sv
hdl/region_descriptor_merge_distance_top.sv
tb/sv/tb_region_descriptor_merge_distance_top.sv
